/* rtl/power_lifecycle_state_machine_assert.svh */
// assertion macros for the rtl of the power lifecycle block
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef POWER_LIFECYCLE_STATE_MACHINE_ASSERT_SVH
`define POWER_LIFECYCLE_STATE_MACHINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define PLSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/plsm_pkg.sv */
// types, codes and reset values for the power lifecycle state machine
// no dependencies
package plsm_pkg;

    // event selector codes
    localparam logic [2:0] FUNC_WAKE_FRAME = 3'd0;
    localparam logic [2:0] FUNC_HOST_SHUT  = 3'd1;
    localparam logic [2:0] FUNC_SUSPEND    = 3'd2;
    localparam logic [2:0] FUNC_REBOOT     = 3'd3;
    localparam logic [2:0] FUNC_QUERY      = 3'd4;
    localparam logic [2:0] FUNC_TIMER_WAKE = 3'd5;
    localparam logic [2:0] FUNC_TICK       = 3'd6;

    // heartbeat kinds
    localparam logic [2:0] HB_NONE     = 3'd0;
    localparam logic [2:0] HB_INIT     = 3'd1;
    localparam logic [2:0] HB_ACTIVE   = 3'd2;
    localparam logic [2:0] HB_DELAY    = 3'd3;
    localparam logic [2:0] HB_SHUTDOWN = 3'd4;
    localparam logic [2:0] HB_REBOOT   = 3'd5;
    localparam logic [2:0] HB_S3       = 3'd6;

    // actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_POWER_OFF = 3'd3;
    localparam logic [2:0] ACT_REBOOT    = 3'd4;
    localparam logic [2:0] ACT_SUSPEND   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_TIMER   = 2'd2;

    localparam logic [7:0]  GOOD_HEADER       = 8'd1;
    localparam logic [23:0] SHUTDOWN_ONLY_BIT = 24'h800000;

    localparam int NUM_STATES = 8;

    // lifecycle states, one-hot; bit position is the state number
    typedef enum logic [7:0] {
        LC_DEFAULT      = 8'b0000_0001,
        LC_ALIVE        = 8'b0000_0010,
        LC_SHUT         = 8'b0000_0100,
        LC_DELAY        = 8'b0000_1000,
        LC_HOST_OFF     = 8'b0001_0000,
        LC_CTRL_OFF     = 8'b0010_0000,
        LC_HOST_REBOOT  = 8'b0100_0000,
        LC_HOST_SUSPEND = 8'b1000_0000
    } lc_state_t;

    // reset values of the allowed-move registers, by register index
    typedef logic [7:0] move_row_t;
    localparam move_row_t MOVE_RESET [NUM_STATES] =
        '{8'd7, 8'd214, 8'd252, 8'd248, 8'd48, 8'd34, 8'd96, 8'd162};

    // one result item
    typedef struct packed {
        logic [2:0]  state_now;
        logic [2:0]  heartbeat_kind;
        logic [2:0]  action;
        logic [1:0]  status;
        logic [23:0] reason_out;
        logic        last;
    } result_t;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // state number of a one-hot state
    function automatic logic [2:0] state_code(input lc_state_t st);
        logic [2:0] code;
        code = 3'd0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            if (st[i])
            begin
                code = code | 3'(i);
            end
        end
        return code;
    endfunction

endpackage

/* rtl/power_lifecycle_state_machine.sv */
// Power lifecycle state machine: takes one event per transfer on the slave side
// (s_tready high) and produces one result, two on the first tick after reset (an init
// heartbeat, then the tick result). An event is decided in the cycle it is accepted
// and its results are written straight into a four-entry result queue, so the first
// result can leave in the next cycle. The block sustains one event per cycle; s_tready
// drops only while the result queue holds more than two entries, i.e. when the master
// side is stalled. Moves are checked against the eight allowed-move registers; the user
// must write them through the cfg port while no event is in flight; not enforced.
// depends on plsm_pkg and power_lifecycle_state_machine_assert.svh
module power_lifecycle_state_machine
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // event stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] frame_header, [31:8] wake_bits
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] state_now, [5:3] heartbeat_kind,
                                   // [8:6] action, [10:9] status,
                                   // [34:11] reason_out, [39:35] zero
    output logic        m_tlast
);

    // architectural state
    plsm_pkg::move_row_t allowed_reg [plsm_pkg::NUM_STATES];
    plsm_pkg::lc_state_t state_reg, state_next;
    plsm_pkg::lc_state_t prev_tick_reg, prev_tick_next;
    logic [23:0]         reason_reg, reason_next;
    logic                init_sent_reg, init_sent_next;

    // result queue
    plsm_pkg::result_t                queue_reg [plsm_pkg::QUEUE_DEPTH];
    logic [plsm_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [plsm_pkg::QCNT_W-1:0]      count_reg, count_next;

    // step decode
    logic                in_xfer, out_xfer;
    logic [2:0]          func;
    logic [7:0]          header;
    logic [23:0]         wake_bits;
    plsm_pkg::move_row_t cur_row;
    plsm_pkg::lc_state_t target;
    logic                move_req;
    logic [2:0]          kind;
    logic [2:0]          act;
    logic [1:0]          status;
    logic [23:0]         reason_q;
    logic                two_results;
    plsm_pkg::result_t   init_res, main_res;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign func      = s_tuser;
    assign header    = s_tdata[7:0];
    assign wake_bits = s_tdata[31:8];

    // allowed-move row of the current state
    always_comb
    begin
        cur_row = '0;
        for (int i = 0; i < plsm_pkg::NUM_STATES; i++)
        begin
            if (state_reg[i])
            begin
                cur_row = cur_row | allowed_reg[i];
            end
        end
    end

    // event decode: requested move, heartbeat, action, status
    always_comb
    begin
        target         = state_reg;
        move_req       = 1'b0;
        kind           = plsm_pkg::HB_NONE;
        act            = plsm_pkg::ACT_NONE;
        status         = plsm_pkg::ST_OK;
        reason_q       = '0;
        reason_next    = reason_reg;
        init_sent_next = init_sent_reg;
        two_results    = 1'b0;
        case (func)
            plsm_pkg::FUNC_WAKE_FRAME:
            begin
                if (header != plsm_pkg::GOOD_HEADER)
                begin
                    status = plsm_pkg::ST_BAD_HEADER;
                end
                else
                begin
                    reason_next = wake_bits;
                    move_req    = 1'b1;
                    if (wake_bits == '0)
                    begin
                        target = plsm_pkg::LC_CTRL_OFF;
                    end
                    else if ((wake_bits & ~plsm_pkg::SHUTDOWN_ONLY_BIT) == '0)
                    begin
                        target = plsm_pkg::LC_SHUT;
                    end
                    else
                    begin
                        target = plsm_pkg::LC_ALIVE;
                    end
                end
            end
            plsm_pkg::FUNC_HOST_SHUT:
            begin
                move_req = 1'b1;
                target   = plsm_pkg::LC_HOST_OFF;
            end
            plsm_pkg::FUNC_SUSPEND:
            begin
                move_req = 1'b1;
                target   = plsm_pkg::LC_HOST_SUSPEND;
            end
            plsm_pkg::FUNC_REBOOT:
            begin
                move_req = 1'b1;
                target   = plsm_pkg::LC_HOST_REBOOT;
            end
            plsm_pkg::FUNC_QUERY:
            begin
                reason_q = reason_reg;
            end
            plsm_pkg::FUNC_TIMER_WAKE:
            begin
                status = plsm_pkg::ST_NO_TIMER;
            end
            plsm_pkg::FUNC_TICK:
            begin
                two_results    = !init_sent_reg;
                init_sent_next = 1'b1;
                case (state_reg)
                    plsm_pkg::LC_ALIVE:
                    begin
                        kind = plsm_pkg::HB_ACTIVE;
                        if (prev_tick_reg != plsm_pkg::LC_ALIVE)
                        begin
                            act = plsm_pkg::ACT_START;
                        end
                    end
                    plsm_pkg::LC_SHUT:
                    begin
                        kind     = plsm_pkg::HB_DELAY;
                        act      = plsm_pkg::ACT_STOP;
                        move_req = 1'b1;
                        target   = plsm_pkg::LC_DELAY;
                    end
                    plsm_pkg::LC_DELAY:        kind = plsm_pkg::HB_DELAY;
                    plsm_pkg::LC_HOST_OFF:     kind = plsm_pkg::HB_SHUTDOWN;
                    plsm_pkg::LC_HOST_REBOOT:  kind = plsm_pkg::HB_REBOOT;
                    plsm_pkg::LC_HOST_SUSPEND: kind = plsm_pkg::HB_S3;
                    plsm_pkg::LC_CTRL_OFF:
                    begin
                        if (prev_tick_reg == plsm_pkg::LC_HOST_OFF)
                        begin
                            act = plsm_pkg::ACT_POWER_OFF;
                        end
                        else if (prev_tick_reg == plsm_pkg::LC_HOST_REBOOT)
                        begin
                            act = plsm_pkg::ACT_REBOOT;
                        end
                        else if (prev_tick_reg == plsm_pkg::LC_HOST_SUSPEND)
                        begin
                            act = plsm_pkg::ACT_SUSPEND;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // move taken only when the current row allows the target
    always_comb
    begin
        state_next = state_reg;
        if (move_req && ((cur_row & target) != '0))
        begin
            state_next = target;
        end
        prev_tick_next = (func == plsm_pkg::FUNC_TICK) ? state_next : prev_tick_reg;
    end

    // result items of this event
    always_comb
    begin
        init_res.state_now      = plsm_pkg::state_code(state_next);
        init_res.heartbeat_kind = plsm_pkg::HB_INIT;
        init_res.action         = plsm_pkg::ACT_NONE;
        init_res.status         = plsm_pkg::ST_OK;
        init_res.reason_out     = '0;
        init_res.last           = 1'b0;

        main_res.state_now      = plsm_pkg::state_code(state_next);
        main_res.heartbeat_kind = kind;
        main_res.action         = act;
        main_res.status         = status;
        main_res.reason_out     = reason_q;
        main_res.last           = 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plsm_pkg::NUM_STATES; i++)
            begin
                allowed_reg[i] <= plsm_pkg::MOVE_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            allowed_reg[cfg_index] <= cfg_data;
        end
    end

    // lifecycle state, updated on each event transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plsm_pkg::LC_DEFAULT;
            prev_tick_reg <= plsm_pkg::LC_DEFAULT;
            reason_reg    <= '0;
            init_sent_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            state_reg     <= state_next;
            prev_tick_reg <= prev_tick_next;
            reason_reg    <= reason_next;
            init_sent_reg <= init_sent_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (two_results)
            begin
                queue_reg[wr_ptr_reg]                            <= init_res;
                queue_reg[wr_ptr_reg + plsm_pkg::QPTR_W'(1)]     <= main_res;
            end
            else
            begin
                queue_reg[wr_ptr_reg] <= main_res;
            end
        end
    end

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (in_xfer)
        begin
            count_next = count_next + (two_results ? plsm_pkg::QCNT_W'(2)
                                                   : plsm_pkg::QCNT_W'(1));
        end
        if (out_xfer)
        begin
            count_next = count_next - plsm_pkg::QCNT_W'(1);
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + (two_results ? plsm_pkg::QPTR_W'(2)
                                                        : plsm_pkg::QPTR_W'(1));
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + plsm_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // ports
    assign s_tready = (count_reg <= plsm_pkg::QCNT_W'(plsm_pkg::QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {5'b0,
                       queue_reg[rd_ptr_reg].reason_out,
                       queue_reg[rd_ptr_reg].status,
                       queue_reg[rd_ptr_reg].action,
                       queue_reg[rd_ptr_reg].heartbeat_kind,
                       queue_reg[rd_ptr_reg].state_now};
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // checks
    `include "power_lifecycle_state_machine_assert.svh"

    `PLSM_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= plsm_pkg::QCNT_W'(plsm_pkg::QUEUE_DEPTH))
    `PLSM_ASSERT_NXT(a_state_holds, !in_xfer, $stable(state_reg) && $stable(prev_tick_reg))
    `PLSM_ASSERT_NXT(a_init_once, in_xfer && two_results, init_sent_reg && m_tvalid)
    `PLSM_ASSERT_IMP(a_pair_only_tick, in_xfer && two_results, func == plsm_pkg::FUNC_TICK)

endmodule

/* tb/sv/power_lifecycle_state_machine_test.sv */
// testbench for the power lifecycle state machine: directed events, then random event
// streams under several allowed-move tables, checked against a behavioral predictor
// depends on plsm_pkg and power_lifecycle_state_machine
`timescale 1ns / 1ps

module power_lifecycle_state_machine_test;

    // state numbers as they appear on state_now
    localparam logic [2:0] SN_DEFAULT      = 3'd0;
    localparam logic [2:0] SN_ALIVE        = 3'd1;
    localparam logic [2:0] SN_SHUT         = 3'd2;
    localparam logic [2:0] SN_DELAY        = 3'd3;
    localparam logic [2:0] SN_HOST_OFF     = 3'd4;
    localparam logic [2:0] SN_CTRL_OFF     = 3'd5;
    localparam logic [2:0] SN_HOST_REBOOT  = 3'd6;
    localparam logic [2:0] SN_HOST_SUSPEND = 3'd7;

    // selector code with no event behind it
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 8;
    localparam int PRINT_LIMIT  = 100;

    typedef enum {MOVES_ALL_ON, MOVES_ALL_OFF, MOVES_RESET, MOVES_RANDOM} move_fill_t;

    // one directed event; the trailing fields are the final result, used when typed is set
    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  header;
        logic [23:0] bits;
        logic        typed;
        logic [2:0]  state_now;
        logic [2:0]  heartbeat_kind;
        logic [2:0]  action;
        logic [1:0]  status;
        logic [23:0] reason_out;
    } plan_row_t;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam int   PLAN_LEN  = 28;

    localparam plan_row_t EVENT_PLAN [PLAN_LEN] = '{
        // right after reset, error codes and ignored events
        '{plsm_pkg::FUNC_QUERY, 8'h00, 24'h000000, TYPED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TIMER_WAKE, 8'hFF, 24'hFFFFFF, TYPED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_NO_TIMER, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h00, 24'h000000, TYPED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_BAD_HEADER, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'hFF, 24'hFFFFFF, TYPED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_BAD_HEADER, 24'd0},
        '{FUNC_UNUSED, 8'hFF, 24'hFFFFFF, TYPED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // refused move, then the first tick with its init heartbeat
        '{plsm_pkg::FUNC_HOST_SHUT, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // shutdown-only reason, tick moves on to shutdown delay
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h800000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_QUERY, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // host shutdown, then controller off gives power off
        '{plsm_pkg::FUNC_HOST_SHUT, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // alive: start guests once, then no action on the next tick
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'hFFFFFF, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // host reboot, then controller off gives reboot
        '{plsm_pkg::FUNC_REBOOT, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        // host suspend, then controller off gives suspend to ram
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h000001, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_SUSPEND, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_WAKE_FRAME, 8'h01, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0},
        '{plsm_pkg::FUNC_TICK, 8'h00, 24'h000000, PREDICTED,
          SN_DEFAULT, plsm_pkg::HB_NONE, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;   // [7:0] frame_header, [31:8] wake_bits
    logic [2:0]  s_tuser   = 3'd0;    // [2:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;             // [2:0] state_now, [5:3] heartbeat_kind, [8:6] action,
                                      // [10:9] status, [34:11] reason_out
    logic        m_tlast;

    // predictor state
    logic [7:0]        move_table [plsm_pkg::NUM_STATES];
    logic [2:0]        lc_now;
    logic [2:0]        tick_prev;
    logic [23:0]       kept_reason;
    bit                init_done;
    plsm_pkg::result_t lifecycle_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int stalled_cycles = 0;

    power_lifecycle_state_machine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // move only where the table row of the current state allows the target
    function automatic void request_move(input logic [2:0] target);
        if (move_table[lc_now][target])
        begin
            lc_now = target;
        end
    endfunction

    function automatic void queue_result(input logic [2:0] kind, input logic [2:0] act,
                                         input logic [1:0] status, input logic [23:0] reason,
                                         input logic last_flag);
        plsm_pkg::result_t r;
        r.state_now      = lc_now;
        r.heartbeat_kind = kind;
        r.action         = act;
        r.status         = status;
        r.reason_out     = reason;
        r.last           = last_flag;
        lifecycle_results.push_back(r);
    endfunction

    // apply one event to the predicted state and queue the results it causes
    function automatic void advance_lifecycle(input logic [2:0] func, input logic [7:0] header,
                                              input logic [23:0] bits);
        logic [2:0]  kind;
        logic [2:0]  act;
        logic [2:0]  cur;
        logic [1:0]  status;
        logic [23:0] reason;
        bit          first_tick;
        kind       = plsm_pkg::HB_NONE;
        act        = plsm_pkg::ACT_NONE;
        status     = plsm_pkg::ST_OK;
        reason     = 24'd0;
        first_tick = 1'b0;
        case (func)
            plsm_pkg::FUNC_WAKE_FRAME:
            begin
                if (header != plsm_pkg::GOOD_HEADER)
                begin
                    status = plsm_pkg::ST_BAD_HEADER;
                end
                else
                begin
                    kept_reason = bits;
                    if (bits == 24'd0)
                        request_move(SN_CTRL_OFF);
                    else if ((bits & ~plsm_pkg::SHUTDOWN_ONLY_BIT) == 24'd0)
                        request_move(SN_SHUT);
                    else
                        request_move(SN_ALIVE);
                end
            end
            plsm_pkg::FUNC_HOST_SHUT:  request_move(SN_HOST_OFF);
            plsm_pkg::FUNC_SUSPEND:    request_move(SN_HOST_SUSPEND);
            plsm_pkg::FUNC_REBOOT:     request_move(SN_HOST_REBOOT);
            plsm_pkg::FUNC_QUERY:      reason = kept_reason;
            plsm_pkg::FUNC_TIMER_WAKE: status = plsm_pkg::ST_NO_TIMER;
            plsm_pkg::FUNC_TICK:
            begin
                cur        = lc_now;
                first_tick = !init_done;
                init_done  = 1'b1;
                case (cur)
                    SN_ALIVE:
                    begin
                        if (tick_prev != SN_ALIVE)
                            act = plsm_pkg::ACT_START;
                        kind = plsm_pkg::HB_ACTIVE;
                    end
                    SN_SHUT:
                    begin
                        act = plsm_pkg::ACT_STOP;
                        request_move(SN_DELAY);
                        cur  = lc_now;
                        kind = plsm_pkg::HB_DELAY;
                    end
                    SN_DELAY:        kind = plsm_pkg::HB_DELAY;
                    SN_HOST_OFF:     kind = plsm_pkg::HB_SHUTDOWN;
                    SN_HOST_REBOOT:  kind = plsm_pkg::HB_REBOOT;
                    SN_HOST_SUSPEND: kind = plsm_pkg::HB_S3;
                    SN_CTRL_OFF:
                    begin
                        if (tick_prev == SN_HOST_OFF)
                            act = plsm_pkg::ACT_POWER_OFF;
                        else if (tick_prev == SN_HOST_REBOOT)
                            act = plsm_pkg::ACT_REBOOT;
                        else if (tick_prev == SN_HOST_SUSPEND)
                            act = plsm_pkg::ACT_SUSPEND;
                    end
                    default: ;
                endcase
                tick_prev = cur;
            end
            default: ;
        endcase
        if (first_tick)
            queue_result(plsm_pkg::HB_INIT, plsm_pkg::ACT_NONE, plsm_pkg::ST_OK, 24'd0, 1'b0);
        queue_result(kind, act, status, reason, 1'b1);
    endfunction

    // present one event, with random idle cycles ahead of it, and predict on its transfer
    task automatic push_event(input logic [2:0] func, input logic [7:0] header,
                              input logic [23:0] bits);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {bits, header};
        do
            @(posedge clk);
        while (!s_tready);
        advance_lifecycle(func, header, bits);
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (lifecycle_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // rewrite all eight allowed-move registers
    task automatic load_move_table(input move_fill_t fill);
        logic [7:0] row;
        for (int i = 0; i < plsm_pkg::NUM_STATES; i++)
        begin
            case (fill)
                MOVES_ALL_ON:  row = 8'hFF;
                MOVES_ALL_OFF: row = 8'h00;
                MOVES_RESET:   row = plsm_pkg::MOVE_RESET[i];
                default:       row = 8'($urandom_range(0, 255));
            endcase
            move_table[i] = row;
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= row;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // random events: mostly well-formed wake frames and ticks, some noise
    task automatic send_random_events(input int count);
        logic [2:0]  func;
        logic [7:0]  header;
        logic [23:0] bits;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            pick   = $urandom_range(0, 99);
            header = 8'($urandom_range(0, 255));
            bits   = 24'($urandom);
            if (pick < 35)
            begin
                func = plsm_pkg::FUNC_WAKE_FRAME;
                if ($urandom_range(0, 9) != 0)
                    header = plsm_pkg::GOOD_HEADER;
                case ($urandom_range(0, 3))
                    0:       bits = 24'd0;
                    1:       bits = plsm_pkg::SHUTDOWN_ONLY_BIT;
                    default: ;
                endcase
            end
            else if (pick < 45)
                func = plsm_pkg::FUNC_HOST_SHUT;
            else if (pick < 53)
                func = plsm_pkg::FUNC_SUSPEND;
            else if (pick < 61)
                func = plsm_pkg::FUNC_REBOOT;
            else if (pick < 67)
                func = plsm_pkg::FUNC_QUERY;
            else if (pick < 71)
                func = plsm_pkg::FUNC_TIMER_WAKE;
            else if (pick < 98)
                func = plsm_pkg::FUNC_TICK;
            else
                func = FUNC_UNUSED;
            push_event(func, header, bits);
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [23:0] got,
                                 input logic [23:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s differs, got %0h, want %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // result side: check each transfer against the oldest prediction, then pick next ready
    always @(posedge clk)
    begin
        plsm_pkg::result_t want;
        if (m_tvalid && m_tready)
        begin
            if (lifecycle_results.size() == 0)
            begin
                flag_mismatch("unpredicted result, state_now", 24'(m_tdata[2:0]), 24'd0);
            end
            else
            begin
                want = lifecycle_results.pop_front();
                if (m_tdata[2:0] !== want.state_now)
                    flag_mismatch("state_now", 24'(m_tdata[2:0]), 24'(want.state_now));
                if (m_tdata[5:3] !== want.heartbeat_kind)
                    flag_mismatch("heartbeat_kind", 24'(m_tdata[5:3]), 24'(want.heartbeat_kind));
                if (m_tdata[8:6] !== want.action)
                    flag_mismatch("action", 24'(m_tdata[8:6]), 24'(want.action));
                if (m_tdata[10:9] !== want.status)
                    flag_mismatch("status", 24'(m_tdata[10:9]), 24'(want.status));
                if (m_tdata[34:11] !== want.reason_out)
                    flag_mismatch("reason_out", m_tdata[34:11], want.reason_out);
                if (m_tlast !== want.last)
                    flag_mismatch("last", 24'(m_tlast), 24'(want.last));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        plsm_pkg::result_t settled;
        for (int i = 0; i < plsm_pkg::NUM_STATES; i++)
            move_table[i] = plsm_pkg::MOVE_RESET[i];
        lc_now      = SN_DEFAULT;
        tick_prev   = SN_DEFAULT;
        kept_reason = 24'd0;
        init_done   = 1'b0;

        send_idle_pct = 31;
        recv_idle_pct = 66;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk through the lifecycle under the reset tables
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            push_event(EVENT_PLAN[i].func, EVENT_PLAN[i].header, EVENT_PLAN[i].bits);
            if (EVENT_PLAN[i].typed)
            begin
                settled = lifecycle_results.pop_back();
                settled.state_now      = EVENT_PLAN[i].state_now;
                settled.heartbeat_kind = EVENT_PLAN[i].heartbeat_kind;
                settled.action         = EVENT_PLAN[i].action;
                settled.status         = EVENT_PLAN[i].status;
                settled.reason_out     = EVENT_PLAN[i].reason_out;
                lifecycle_results.push_back(settled);
            end
        end

        drain_results();
        load_move_table(MOVES_ALL_ON);
        send_random_events(180);
        drain_results();
        load_move_table(MOVES_RANDOM);
        send_random_events(180);

        send_idle_pct = 66;
        recv_idle_pct = 31;
        drain_results();
        load_move_table(MOVES_ALL_OFF);
        send_random_events(60);
        drain_results();
        load_move_table(MOVES_RESET);
        send_random_events(240);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_results();
        load_move_table(MOVES_RANDOM);
        send_random_events(200);
        drain_results();
        load_move_table(MOVES_RANDOM);
        send_random_events(200);

        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
